[hw/rtl/i2cm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    localparam logic [15:0] HalfPeriodReset = 16'd100;

    // input queue between front and back
    localparam int QueueDepth = 4;
    localparam int QueueAw    = $clog2(QueueDepth);

    localparam logic [3:0] ByteBits = 4'd8;

    localparam logic [1:0] OpTick  = 2'd0;
    localparam logic [1:0] OpWrite = 2'd1;
    localparam logic [1:0] OpRead  = 2'd2;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic       with_start;
        logic       with_stop;
        logic [7:0] write_data;
        logic       send_nack;
        logic       scl_in;
        logic       sda_in;
    } item_t;

    typedef enum logic [14:0] {
        PH_IDLE    = 15'h0001,
        PH_RS_D1   = 15'h0002,
        PH_RS_W    = 15'h0004,
        PH_RS_D2   = 15'h0008,
        PH_ST_D    = 15'h0010,
        PH_W_SETUP = 15'h0020,
        PH_W_WAIT  = 15'h0040,
        PH_W_HOLD  = 15'h0080,
        PH_R_SETUP = 15'h0100,
        PH_R_WAIT  = 15'h0200,
        PH_R_HOLD  = 15'h0400,
        PH_SP_D1   = 15'h0800,
        PH_SP_W    = 15'h1000,
        PH_SP_D2   = 15'h2000,
        PH_SP_D3   = 15'h4000
    } phase_t;

endpackage

`default_nettype wire

[hw/rtl/i2c_master_byte_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake                payload
// in        in_valid / in_stall      op, with_start, with_stop, write_data, send_nack,
//                                    scl_in, sda_in
// out       out_valid / out_stall    scl_drive_low, sda_drive_low, busy_res, done_res,
//                                    read_data, nack_received, arb_lost_res
// cfg       cfg_valid / cfg_ready    cfg_data (half_period_ticks)
//
// one item per clock while in_stall and out_stall stay low; each item gives one result
// through the queue write and then the bus sequencer step into the result register
// a four-entry queue sits between the front and the sequencer, so in_stall rises
// only after out_stall has held the result long enough to fill it
// reset: bus lines released, sequencer idle, half period 100 ticks
// cfg_ready is always high

module i2c_master_byte_engine
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic        with_start,
    input  wire logic        with_stop,
    input  wire logic [7:0]  write_data,
    input  wire logic        send_nack,
    input  wire logic        scl_in,
    input  wire logic        sda_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             scl_drive_low,
    output logic             sda_drive_low,
    output logic             busy_res,
    output logic             done_res,
    output logic [7:0]       read_data,
    output logic             nack_received,
    output logic             arb_lost_res,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    import i2cm_pkg::*;

    logic [15:0] half_period_reg;
    logic [15:0] half_period_next;
    logic        q_valid;
    logic        q_pop;
    item_t       q_item;

    assign cfg_ready        = 1'b1;
    assign half_period_next = (cfg_valid && cfg_ready) ? cfg_data : half_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HalfPeriodReset;
        end
        else
        begin
            half_period_reg <= half_period_next;
        end
    end

    i2cm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .with_start (with_start),
        .with_stop  (with_stop),
        .write_data (write_data),
        .send_nack  (send_nack),
        .scl_in     (scl_in),
        .sda_in     (sda_in),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    i2cm_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .half_period      (half_period_reg),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .scl_drive_low    (scl_drive_low),
        .sda_drive_low    (sda_drive_low),
        .busy_res         (busy_res),
        .done_res         (done_res),
        .read_data        (read_data),
        .nack_received    (nack_received),
        .arb_lost_res     (arb_lost_res)
    );

endmodule

`default_nettype wire

[hw/rtl/i2cm_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [1:0]    op,
    input  wire logic          with_start,
    input  wire logic          with_stop,
    input  wire logic [7:0]    write_data,
    input  wire logic          send_nack,
    input  wire logic          scl_in,
    input  wire logic          sda_in,
    output logic               q_valid,
    output i2cm_pkg::item_t    q_item,
    input  wire logic          q_pop
);
    import i2cm_pkg::*;

    item_t              mem [QueueDepth];
    item_t              in_item;
    logic [QueueAw-1:0] wr_ptr_reg;
    logic [QueueAw-1:0] wr_ptr_next;
    logic [QueueAw-1:0] rd_ptr_reg;
    logic [QueueAw-1:0] rd_ptr_next;
    logic [QueueAw:0]   count_reg;
    logic [QueueAw:0]   count_next;
    logic               push;
    cmd_t               cmd;

    // op 3 and op 0 are both plain ticks
    always_comb
    begin
        unique case (op)
            OpWrite: cmd = CMD_WRITE;
            OpRead:  cmd = CMD_READ;
            default: cmd = CMD_NONE;
        endcase
    end

    always_comb
    begin
        in_item.cmd        = cmd;
        in_item.with_start = with_start;
        in_item.with_stop  = with_stop;
        in_item.write_data = write_data;
        in_item.send_nack  = send_nack;
        in_item.scl_in     = scl_in;
        in_item.sda_in     = sda_in;
    end

    assign in_stall = (count_reg == (QueueAw+1)'(QueueDepth));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QueueAw+1)'(push) - (QueueAw+1)'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/i2cm_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2cm_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [15:0]   half_period,
    input  wire logic          q_valid,
    input  i2cm_pkg::item_t    q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic               scl_drive_low,
    output logic               sda_drive_low,
    output logic               busy_res,
    output logic               done_res,
    output logic [7:0]         read_data,
    output logic               nack_received,
    output logic               arb_lost_res
);
    import i2cm_pkg::*;

    phase_t      phase_reg,    phase_next;
    logic [3:0]  bit_cnt_reg,  bit_cnt_next;
    logic [7:0]  shift_reg,    shift_next;
    logic        open_reg,     open_next;
    logic [15:0] delay_reg,    delay_next;
    logic        scl_low_reg,  scl_low_next;
    logic        sda_low_reg,  sda_low_next;
    logic        pend_stop_reg, pend_stop_next;
    logic        ack_send_reg, ack_send_next;
    logic [7:0]  rx_reg,       rx_next;
    logic        ack_seen_reg, ack_seen_next;
    logic        arb_reg,      arb_next;
    logic        done_reg,     done_next;
    logic        out_valid_reg, out_valid_next;

    logic [15:0] delay_load;
    logic        delay_over;
    logic [3:0]  bit_inc;
    logic        cur_lt8;
    logic        inc_lt8;

    // result slot free or being taken this cycle
    assign q_pop = q_valid && (!out_valid_reg || !out_stall);

    assign delay_load = (half_period == '0) ? 16'd1 : half_period;
    assign delay_over = (delay_reg <= 16'd1);
    assign bit_inc    = bit_cnt_reg + 4'd1;
    assign cur_lt8    = (bit_cnt_reg < ByteBits);
    assign inc_lt8    = (bit_inc < ByteBits);

    always_comb
    begin
        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        open_next      = open_reg;
        delay_next     = delay_reg;
        scl_low_next   = scl_low_reg;
        sda_low_next   = sda_low_reg;
        pend_stop_next = pend_stop_reg;
        ack_send_next  = ack_send_reg;
        rx_next        = rx_reg;
        ack_seen_next  = ack_seen_reg;
        arb_next       = arb_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (q_pop)
        begin
            out_valid_next = 1'b1;
            done_next      = 1'b0;
            if (!delay_over)
            begin
                delay_next = delay_reg - 16'd1;
            end

            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (q_item.cmd == CMD_WRITE)
                    begin
                        shift_next     = q_item.write_data;
                        pend_stop_next = q_item.with_stop;
                        bit_cnt_next   = '0;
                        delay_next     = delay_load;
                        if (q_item.with_start && open_reg)
                        begin
                            // repeated start: release sda first
                            sda_low_next = 1'b0;
                            phase_next   = PH_RS_D1;
                        end
                        else if (q_item.with_start)
                        begin
                            if (!q_item.sda_in)
                            begin
                                arb_next = 1'b1;
                            end
                            sda_low_next = 1'b1;
                            phase_next   = PH_ST_D;
                        end
                        else
                        begin
                            sda_low_next = !q_item.write_data[7];
                            phase_next   = PH_W_SETUP;
                        end
                    end
                    else if (q_item.cmd == CMD_READ)
                    begin
                        ack_send_next  = q_item.send_nack;
                        pend_stop_next = q_item.with_stop;
                        bit_cnt_next   = '0;
                        shift_next     = '0;
                        sda_low_next   = 1'b0;
                        delay_next     = delay_load;
                        phase_next     = PH_R_SETUP;
                    end
                end
                PH_RS_D1:
                begin
                    if (delay_over)
                    begin
                        scl_low_next = 1'b0;
                        phase_next   = PH_RS_W;
                    end
                end
                PH_RS_W:
                begin
                    if (q_item.scl_in)
                    begin
                        delay_next = delay_load;
                        phase_next = PH_RS_D2;
                    end
                end
                PH_RS_D2:
                begin
                    if (delay_over)
                    begin
                        if (!q_item.sda_in)
                        begin
                            arb_next = 1'b1;
                        end
                        sda_low_next = 1'b1;
                        delay_next   = delay_load;
                        phase_next   = PH_ST_D;
                    end
                end
                PH_ST_D:
                begin
                    if (delay_over)
                    begin
                        scl_low_next = 1'b1;
                        open_next    = 1'b1;
                        bit_cnt_next = '0;
                        sda_low_next = !shift_reg[7];
                        delay_next   = delay_load;
                        phase_next   = PH_W_SETUP;
                    end
                end
                PH_W_SETUP:
                begin
                    if (delay_over)
                    begin
                        scl_low_next = 1'b0;
                        phase_next   = PH_W_WAIT;
                    end
                end
                PH_R_SETUP:
                begin
                    if (delay_over)
                    begin
                        scl_low_next = 1'b0;
                        phase_next   = PH_R_WAIT;
                    end
                end
                PH_W_WAIT:
                begin
                    // waits here while the slave stretches scl
                    if (q_item.scl_in)
                    begin
                        if (cur_lt8)
                        begin
                            if (shift_reg[7] && !q_item.sda_in)
                            begin
                                arb_next = 1'b1;
                            end
                            shift_next = {shift_reg[6:0], 1'b0};
                        end
                        else
                        begin
                            ack_seen_next = q_item.sda_in;
                        end
                        delay_next = delay_load;
                        phase_next = PH_W_HOLD;
                    end
                end
                PH_R_WAIT:
                begin
                    if (q_item.scl_in)
                    begin
                        if (cur_lt8)
                        begin
                            shift_next = {shift_reg[6:0], q_item.sda_in};
                        end
                        else if (ack_send_reg && !q_item.sda_in)
                        begin
                            arb_next = 1'b1;
                        end
                        delay_next = delay_load;
                        phase_next = PH_R_HOLD;
                    end
                end
                PH_W_HOLD, PH_R_HOLD:
                begin
                    if (delay_over)
                    begin
                        scl_low_next = 1'b1;
                        if (cur_lt8)
                        begin
                            bit_cnt_next = bit_inc;
                            delay_next   = delay_load;
                            if (phase_reg == PH_W_HOLD)
                            begin
                                // ack slot of a write releases sda
                                sda_low_next = inc_lt8 ? !shift_reg[7] : 1'b0;
                                phase_next   = PH_W_SETUP;
                            end
                            else
                            begin
                                sda_low_next = inc_lt8 ? 1'b0 : !ack_send_reg;
                                phase_next   = PH_R_SETUP;
                            end
                        end
                        else
                        begin
                            if (phase_reg == PH_R_HOLD)
                            begin
                                rx_next = shift_reg;
                            end
                            bit_cnt_next = '0;
                            if (pend_stop_reg)
                            begin
                                sda_low_next = 1'b1;
                                delay_next   = delay_load;
                                phase_next   = PH_SP_D1;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                done_next  = 1'b1;
                            end
                        end
                    end
                end
                PH_SP_D1:
                begin
                    if (delay_over)
                    begin
                        scl_low_next = 1'b0;
                        phase_next   = PH_SP_W;
                    end
                end
                PH_SP_W:
                begin
                    if (q_item.scl_in)
                    begin
                        delay_next = delay_load;
                        phase_next = PH_SP_D2;
                    end
                end
                PH_SP_D2:
                begin
                    if (delay_over)
                    begin
                        sda_low_next = 1'b0;
                        delay_next   = delay_load;
                        phase_next   = PH_SP_D3;
                    end
                end
                PH_SP_D3:
                begin
                    // stop check: released sda must read high
                    if (delay_over)
                    begin
                        if (!q_item.sda_in)
                        begin
                            arb_next = 1'b1;
                        end
                        open_next  = 1'b0;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            open_reg      <= 1'b0;
            delay_reg     <= '0;
            scl_low_reg   <= 1'b0;
            sda_low_reg   <= 1'b0;
            pend_stop_reg <= 1'b0;
            ack_send_reg  <= 1'b0;
            rx_reg        <= '0;
            ack_seen_reg  <= 1'b0;
            arb_reg       <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            open_reg      <= open_next;
            delay_reg     <= delay_next;
            scl_low_reg   <= scl_low_next;
            sda_low_reg   <= sda_low_next;
            pend_stop_reg <= pend_stop_next;
            ack_send_reg  <= ack_send_next;
            rx_reg        <= rx_next;
            ack_seen_reg  <= ack_seen_next;
            arb_reg       <= arb_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // state only moves on a step, so a held result reads straight from it
    assign out_valid        = out_valid_reg;
    assign scl_drive_low    = scl_low_reg;
    assign sda_drive_low    = sda_low_reg;
    assign busy_res         = (phase_reg != PH_IDLE);
    assign done_res         = done_reg;
    assign read_data        = rx_reg;
    assign nack_received    = ack_seen_reg;
    assign arb_lost_res     = arb_reg;

endmodule

`default_nettype wire

[hw/rtl/i2cm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2cm_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        scl_drive_low,
    input wire logic        sda_drive_low,
    input wire logic        busy_res,
    input wire logic        done_res,
    input wire logic [7:0]  read_data,
    input wire logic        arb_lost_res
);

    // held result keeps valid, read data, done, busy and the drive bits
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data)
            && $stable(done_res) && $stable(busy_res) && $stable(scl_drive_low)
            && $stable(sda_drive_low))
        else $error("stalled result changed");

    // a finishing item leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done while busy");

    // two finishes cannot follow each other
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && done_res |=> !(out_valid && done_res))
        else $error("done on consecutive items");

    // arbitration flag is sticky
    a_arb_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        arb_lost_res |=> arb_lost_res)
        else $error("arbitration flag cleared");

endmodule

bind i2c_master_byte_engine i2cm_checker u_checker (.*);

`default_nettype wire

[tb/i2c_master_byte_engine_tb.sv]
`timescale 1ns / 1ps

module i2c_master_byte_engine_tb;
    import i2cm_pkg::*;

    localparam logic [1:0] OpSpare = 2'd3;
    localparam int HoldCycles = 60;
    localparam int SettleCycles = 8;
    localparam int ChunkTicks = 40;

    typedef struct packed {
        logic [1:0] op;
        logic       with_start;
        logic       with_stop;
        logic [7:0] write_data;
        logic       send_nack;
        logic       scl_in;
        logic       sda_in;
    } tick_item_t;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       nack;
        logic       arb;
    } bus_status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = OpTick;
    logic        with_start = 1'b0;
    logic        with_stop = 1'b0;
    logic [7:0]  write_data = 8'h00;
    logic        send_nack = 1'b0;
    logic        scl_in = 1'b1;
    logic        sda_in = 1'b1;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        scl_drive_low;
    logic        sda_drive_low;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  read_data;
    logic        nack_received;
    logic        arb_lost_res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'h0000;

    i2c_master_byte_engine dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .op               (op),
        .with_start       (with_start),
        .with_stop        (with_stop),
        .write_data       (write_data),
        .send_nack        (send_nack),
        .scl_in           (scl_in),
        .sda_in           (sda_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .scl_drive_low    (scl_drive_low),
        .sda_drive_low    (sda_drive_low),
        .busy_res         (busy_res),
        .done_res         (done_res),
        .read_data        (read_data),
        .nack_received    (nack_received),
        .arb_lost_res     (arb_lost_res),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // engine mirror
    logic [15:0] half_per = HalfPeriodReset;
    phase_t      ph = PH_IDLE;
    logic [3:0]  nbits = '0;
    logic [7:0]  shreg = '0;
    logic        xfer_open = 1'b0;
    logic [15:0] dly = '0;
    logic        scl_low = 1'b0;
    logic        sda_low = 1'b0;
    logic        stop_pend = 1'b0;
    logic        ack_bit = 1'b0;
    logic [7:0]  rx_byte = '0;
    logic        ack_seen = 1'b0;
    logic        arb_lost = 1'b0;
    logic        done_now = 1'b0;

    bus_status_t expected_status[$];
    tick_item_t  tick_backlog[$];
    int          ticks_queued = 0;
    int          ticks_offered = 0;
    int          ticks_taken = 0;
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_asks = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    logic        clean_bus = 1'b1;

    function automatic logic roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void arm_delay(phase_t next);
        dly = (half_per == 16'd0) ? 16'd1 : half_per;
        ph = next;
    endfunction

    function automatic logic delay_done();
        if (dly > 16'd1)
        begin
            dly = dly - 16'd1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void write_slot();
        logic b;
        b = (nbits < ByteBits) ? shreg[7] : 1'b1;
        sda_low = ~b;
        arm_delay(PH_W_SETUP);
    endfunction

    function automatic void read_slot();
        logic b;
        b = (nbits < ByteBits) ? 1'b1 : ack_bit;
        sda_low = ~b;
        arm_delay(PH_R_SETUP);
    endfunction

    function automatic void open_start(logic sda);
        if (!sda)
            arb_lost = 1'b1;
        sda_low = 1'b1;
        arm_delay(PH_ST_D);
    endfunction

    function automatic void finish_byte();
        nbits = '0;
        if (stop_pend)
        begin
            sda_low = 1'b1;
            arm_delay(PH_SP_D1);
        end
        else
        begin
            ph = PH_IDLE;
            done_now = 1'b1;
        end
    endfunction

    // one bus tick of the engine, returns the status it reports
    function automatic bus_status_t bus_step(tick_item_t t);
        bus_status_t r;
        done_now = 1'b0;
        case (ph)
            PH_IDLE:
                if (t.op == OpWrite)
                begin
                    shreg = t.write_data;
                    stop_pend = t.with_stop;
                    nbits = '0;
                    if (!t.with_start)
                        write_slot();
                    else if (xfer_open)
                    begin
                        sda_low = 1'b0;
                        arm_delay(PH_RS_D1);
                    end
                    else
                        open_start(t.sda_in);
                end
                else if (t.op == OpRead)
                begin
                    ack_bit = t.send_nack;
                    stop_pend = t.with_stop;
                    nbits = '0;
                    shreg = '0;
                    read_slot();
                end
            PH_RS_D1:
                if (delay_done())
                begin
                    scl_low = 1'b0;
                    ph = PH_RS_W;
                end
            PH_RS_W:
                if (t.scl_in)
                    arm_delay(PH_RS_D2);
            PH_RS_D2:
                if (delay_done())
                    open_start(t.sda_in);
            PH_ST_D:
                if (delay_done())
                begin
                    scl_low = 1'b1;
                    xfer_open = 1'b1;
                    nbits = '0;
                    write_slot();
                end
            PH_W_SETUP:
                if (delay_done())
                begin
                    scl_low = 1'b0;
                    ph = PH_W_WAIT;
                end
            PH_R_SETUP:
                if (delay_done())
                begin
                    scl_low = 1'b0;
                    ph = PH_R_WAIT;
                end
            PH_W_WAIT:
                if (t.scl_in)
                begin
                    if (nbits < ByteBits)
                    begin
                        if (shreg[7] && !t.sda_in)
                            arb_lost = 1'b1;
                        shreg = {shreg[6:0], 1'b0};
                    end
                    else
                        ack_seen = t.sda_in;
                    arm_delay(PH_W_HOLD);
                end
            PH_R_WAIT:
                if (t.scl_in)
                begin
                    if (nbits < ByteBits)
                        shreg = {shreg[6:0], t.sda_in};
                    else if (ack_bit && !t.sda_in)
                        arb_lost = 1'b1;
                    arm_delay(PH_R_HOLD);
                end
            PH_W_HOLD:
                if (delay_done())
                begin
                    scl_low = 1'b1;
                    if (nbits < ByteBits)
                    begin
                        nbits = nbits + 4'd1;
                        write_slot();
                    end
                    else
                        finish_byte();
                end
            PH_R_HOLD:
                if (delay_done())
                begin
                    scl_low = 1'b1;
                    if (nbits < ByteBits)
                    begin
                        nbits = nbits + 4'd1;
                        read_slot();
                    end
                    else
                    begin
                        rx_byte = shreg;
                        finish_byte();
                    end
                end
            PH_SP_D1:
                if (delay_done())
                begin
                    scl_low = 1'b0;
                    ph = PH_SP_W;
                end
            PH_SP_W:
                if (t.scl_in)
                    arm_delay(PH_SP_D2);
            PH_SP_D2:
                if (delay_done())
                begin
                    sda_low = 1'b0;
                    arm_delay(PH_SP_D3);
                end
            PH_SP_D3:
                if (delay_done())
                begin
                    if (!t.sda_in)
                        arb_lost = 1'b1;
                    xfer_open = 1'b0;
                    ph = PH_IDLE;
                    done_now = 1'b1;
                end
            default:
                ph = PH_IDLE;
        endcase
        r.scl_low = scl_low;
        r.sda_low = sda_low;
        r.busy = (ph != PH_IDLE);
        r.done = done_now;
        r.rx_byte = rx_byte;
        r.nack = ack_seen;
        r.arb = arb_lost;
        return r;
    endfunction

    // well-behaved slave when clean_bus is set: only pulls sda where the master samples data or ack
    function automatic logic bus_sda(logic slave_bit);
        if (!clean_bus)
            return slave_bit;
        if (ph == PH_IDLE)
            return 1'b1;
        if (sda_low)
            return 1'b0;
        if ((ph == PH_R_WAIT && nbits < ByteBits) || (ph == PH_W_WAIT && nbits == ByteBits))
            return slave_bit;
        return 1'b1;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // sender
    always @(negedge clk)
    begin
        tick_item_t t;
        if (rst_n && ticks_offered == ticks_taken)
        begin
            if (tick_backlog.size() != 0 && !roll(send_idle_pct))
            begin
                t = tick_backlog.pop_front();
                op <= t.op;
                with_start <= t.with_start;
                with_stop <= t.with_stop;
                write_data <= t.write_data;
                send_nack <= t.send_nack;
                scl_in <= t.scl_in;
                sda_in <= bus_sda(t.sda_in);
                in_valid <= 1'b1;
                ticks_offered <= ticks_offered + 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // long receiver hold-off on request
    always @(negedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_asks != hold_served)
        begin
            hold_left <= HoldCycles;
            hold_served <= hold_asks;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= (hold_left != 0) || roll(stall_pct);
    end

    always @(posedge clk)
    begin
        tick_item_t  t;
        bus_status_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                t = {op, with_start, with_stop, write_data, send_nack, scl_in, sda_in};
                expected_status.push_back(bus_step(t));
                ticks_taken <= ticks_taken + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_status.size() == 0)
                begin
                    $display("%0t: result with nothing expected", $time);
                    mismatches++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("scl_drive_low", want.scl_low, scl_drive_low);
                    check_field("sda_drive_low", want.sda_low, sda_drive_low);
                    check_field("busy_res", want.busy, busy_res);
                    check_field("done_res", want.done, done_res);
                    check_field("read_data", want.rx_byte, read_data);
                    check_field("nack_received", want.nack, nack_received);
                    check_field("arb_lost_res", want.arb, arb_lost_res);
                end
            end
        end
    end

    task automatic push_item(logic [1:0] o, logic st, logic sp, logic [7:0] d, logic nk,
                             logic scl, logic sda);
        tick_backlog.push_back({o, st, sp, d, nk, scl, sda});
        ticks_queued++;
    endtask

    task automatic push_ticks(int n, logic stretch);
        for (int i = 0; i < n; i++)
            push_item(roll(5) ? OpSpare : OpTick, rand_bit(), rand_bit(),
                      rand_byte(), rand_bit(),
                      stretch ? 1'b0 : roll(80), rand_bit());
    endtask

    // one command, then bus ticks, with the odd command landing while busy
    task automatic push_burst();
        int hp;
        int n;
        hp = (half_per == 16'd0) ? 1 : int'(half_per);
        push_item(roll(60) ? OpWrite : OpRead, rand_bit(), roll(30),
                  rand_byte(), rand_bit(), roll(80), rand_bit());
        n = $urandom_range(hp * 20 + 20, hp * 30 + 40);
        for (int i = 0; i < n; i++)
        begin
            if (roll(4))
                push_item(roll(50) ? OpWrite : OpRead, rand_bit(), roll(30),
                          rand_byte(), rand_bit(), roll(80), rand_bit());
            else
                push_ticks(1, 1'b0);
        end
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 52;
                stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct = 52;
            end
            default:
            begin
                send_idle_pct = 31;
                stall_pct = 31;
            end
        endcase
    endtask

    task automatic drain();
        while (tick_backlog.size() != 0 || ticks_taken != ticks_queued ||
               expected_status.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    // clock the engine back to idle before touching the register
    task automatic wind_down();
        drain();
        while (ph != PH_IDLE)
        begin
            push_ticks(16, 1'b0);
            drain();
        end
    endtask

    task automatic set_half_period(logic [15:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        half_per = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int chunk_start;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_half_period(16'd1);
        // start, repeated start, data extremes
        push_item(OpWrite, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1);
        push_ticks(40, 1'b0);
        push_item(OpWrite, 1'b1, 1'b0, 8'hFF, 1'b0, 1'b1, 1'b1);
        push_ticks(40, 1'b0);
        // write without start, plus a read that arrives while busy
        push_item(OpWrite, 1'b0, 1'b1, 8'hA5, 1'b0, 1'b1, 1'b1);
        push_ticks(3, 1'b0);
        push_item(OpRead, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1);
        push_ticks(40, 1'b0);
        // read on a closed transfer with ack, then read with start flag and nack + stop
        push_item(OpRead, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
        push_ticks(40, 1'b0);
        push_item(OpRead, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b1);
        push_ticks(40, 1'b0);
        push_item(OpSpare, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1);
        // slave holds scl low mid byte
        push_item(OpWrite, 1'b1, 1'b1, 8'h3C, 1'b0, 1'b1, 1'b1);
        push_ticks(6, 1'b0);
        push_ticks(15, 1'b1);
        push_ticks(40, 1'b0);
        push_item(OpRead, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1);
        push_ticks(40, 1'b0);
        push_item(OpWrite, 1'b0, 1'b0, 8'h81, 1'b1, 1'b1, 1'b1);
        push_ticks(40, 1'b0);
        wind_down();

        for (int k = 0; k < 3; k++)
        begin
            set_half_period(k == 0 ? 16'd0 : (k == 1 ? 16'd3 : 16'd2));
            for (int m = 0; m < 4; m++)
            begin
                set_idling(m);
                if (k == 0 && m == 0)
                    hold_asks++;
                chunk_start = ticks_queued;
                while (ticks_queued - chunk_start < ChunkTicks)
                    push_burst();
                while (tick_backlog.size() != 0)
                    @(negedge clk);
                if (m == 1)
                    drain();
            end
            wind_down();
        end

        // noisy bus: released sda pulled low at random, start with sda low
        clean_bus = 1'b0;
        set_idling(3);
        push_item(OpWrite, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0);
        push_ticks(60, 1'b0);
        chunk_start = ticks_queued;
        while (ticks_queued - chunk_start < ChunkTicks)
            push_burst();
        wind_down();

        // widest half period: the command only starts its first delay
        set_half_period(16'hFFFF);
        set_idling(0);
        push_item(OpWrite, 1'b1, 1'b1, 8'h96, 1'b0, 1'b1, 1'b1);
        push_ticks(40, 1'b0);
        drain();

        if (mismatches == 0)
            $display("i2c_master_byte_engine test passed");
        else
            $display("i2c_master_byte_engine test failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("i2c_master_byte_engine test failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_front.sv
hw/rtl/i2cm_back.sv
hw/rtl/i2c_master_byte_engine.sv
hw/rtl/i2cm_checker.sv
tb/i2c_master_byte_engine_tb.sv
